// File: rtl/lcge_pkg.sv
`default_nettype none

package lcge_pkg;

	localparam int POP_W     = 13;
	localparam int ADDR_W    = 6;
	localparam int NB_NUM    = 8;
	localparam int NB_W      = $clog2(NB_NUM);
	localparam int SUM_W     = $clog2(NB_NUM + 1);
	localparam int BORN_CNT  = 3;
	localparam int KEEP_CNT  = 2;
	localparam logic [POP_W-1:0] MAX_LIVE = POP_W'(4096);

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_EVAL  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	localparam logic [1:0] OFS_NEG  = 2'b11;
	localparam logic [1:0] OFS_ZERO = 2'b00;
	localparam logic [1:0] OFS_POS  = 2'b01;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [ADDR_W-1:0] row;
		logic [ADDR_W-1:0] col;
		logic              cell_value;
		logic              center_dead;
	} req_t;

	typedef struct packed {
		logic             next_state;
		logic [POP_W-1:0] live_count;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_INIT_CLR,
		ST_IDLE,
		ST_REQ_CLR,
		ST_WR_RD,
		ST_WR_UPD,
		ST_EV_RD,
		ST_EV_LAST,
		ST_RSP
	} state_t;

	typedef struct packed {
		logic load;
		logic clr_step;
		logic wr_rd;
		logic wr_upd;
		logic ev_rd;
		logic rsp;
	} cmd_t;

	typedef struct packed {
		logic in_grid;
		logic clr_last;
		logic nb_last;
	} stat_t;

	// neighbor k: row offset, scanned top row, middle row, bottom row
	function automatic logic [1:0] nb_dr(input logic [NB_W-1:0] k);
		logic [1:0] d;
		case (k)
			3'd0, 3'd1, 3'd2: d = OFS_NEG;
			3'd3, 3'd4:       d = OFS_ZERO;
			default:          d = OFS_POS;
		endcase
		return d;
	endfunction

	function automatic logic [1:0] nb_dc(input logic [NB_W-1:0] k);
		logic [1:0] d;
		case (k)
			3'd0, 3'd3, 3'd5: d = OFS_NEG;
			3'd1, 3'd6:       d = OFS_ZERO;
			default:          d = OFS_POS;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

// File: rtl/lcge_ctrl.sv
`default_nettype none

module lcge_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [1:0]    req_type,
	input  wire lcge_pkg::stat_t stat,
	output lcge_pkg::cmd_t     cmd,
	output logic               busy,
	output logic               done
);

	lcge_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcge_pkg::ST_INIT_CLR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			lcge_pkg::ST_INIT_CLR: begin
				if (stat.clr_last) state_nxt = lcge_pkg::ST_IDLE;
			end
			lcge_pkg::ST_IDLE: begin
				if (start) begin
					case (req_type)
						lcge_pkg::REQ_WRITE:
							state_nxt = stat.in_grid ? lcge_pkg::ST_WR_RD : lcge_pkg::ST_RSP;
						lcge_pkg::REQ_EVAL:
							state_nxt = stat.in_grid ? lcge_pkg::ST_EV_RD : lcge_pkg::ST_RSP;
						lcge_pkg::REQ_CLEAR:
							state_nxt = lcge_pkg::ST_REQ_CLR;
						default:
							state_nxt = lcge_pkg::ST_RSP;
					endcase
				end
			end
			lcge_pkg::ST_REQ_CLR: begin
				if (stat.clr_last) state_nxt = lcge_pkg::ST_RSP;
			end
			lcge_pkg::ST_WR_RD:   state_nxt = lcge_pkg::ST_WR_UPD;
			lcge_pkg::ST_WR_UPD:  state_nxt = lcge_pkg::ST_RSP;
			lcge_pkg::ST_EV_RD: begin
				if (stat.nb_last) state_nxt = lcge_pkg::ST_EV_LAST;
			end
			lcge_pkg::ST_EV_LAST: state_nxt = lcge_pkg::ST_RSP;
			lcge_pkg::ST_RSP:     state_nxt = lcge_pkg::ST_IDLE;
			default:              state_nxt = lcge_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			lcge_pkg::ST_INIT_CLR: cmd.clr_step = 1'b1;
			lcge_pkg::ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			lcge_pkg::ST_REQ_CLR:  cmd.clr_step = 1'b1;
			lcge_pkg::ST_WR_RD:    cmd.wr_rd = 1'b1;
			lcge_pkg::ST_WR_UPD:   cmd.wr_upd = 1'b1;
			lcge_pkg::ST_EV_RD:    cmd.ev_rd = 1'b1;
			lcge_pkg::ST_EV_LAST:  cmd = '0;
			lcge_pkg::ST_RSP: begin
				cmd.rsp = 1'b1;
				done    = 1'b1;
			end
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/lcge_dpath.sv
`default_nettype none

module lcge_dpath #(
	parameter int GRID_ROWS = 64,
	parameter int GRID_COLS = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire lcge_pkg::req_t req,
	input  wire lcge_pkg::cmd_t cmd,
	output lcge_pkg::stat_t     stat,
	output lcge_pkg::rsp_t      rsp
);

	localparam int CELLS  = GRID_ROWS * GRID_COLS;
	localparam int CELL_W = $clog2(CELLS);
	localparam int NR_W   = lcge_pkg::ADDR_W + 1;

	lcge_pkg::req_t req_q;

	logic                       mem_q [CELLS];
	logic                       rd_data_q;
	logic [CELL_W-1:0]          mem_addr;
	logic                       mem_we;
	logic                       mem_wd;

	logic [CELL_W-1:0]          clr_addr_q;
	logic [lcge_pkg::NB_W-1:0]  nb_q;
	logic                       nb_vld_s1;
	logic [lcge_pkg::SUM_W-1:0] sum_q;
	logic [lcge_pkg::POP_W-1:0] pop_q;

	logic [1:0]                 dr, dc;
	logic [NR_W-1:0]            nrow, ncol;
	logic                       nb_ok;
	logic [CELL_W-1:0]          nb_addr, ctr_addr;
	logic                       alive;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
	end

	assign dr   = lcge_pkg::nb_dr(nb_q);
	assign dc   = lcge_pkg::nb_dc(nb_q);
	assign nrow = NR_W'({1'b0, req_q.row}) + {{(NR_W-2){dr[1]}}, dr};
	assign ncol = NR_W'({1'b0, req_q.col}) + {{(NR_W-2){dc[1]}}, dc};

	// no wrap: off-grid neighbors never touch the memory
	assign nb_ok = !(dr == lcge_pkg::OFS_NEG && req_q.row == '0)
	            && !(dc == lcge_pkg::OFS_NEG && req_q.col == '0)
	            && (32'(nrow) < GRID_ROWS) && (32'(ncol) < GRID_COLS);

	assign nb_addr  = CELL_W'(CELL_W'(nrow) * CELL_W'(GRID_COLS) + CELL_W'(ncol));
	assign ctr_addr = CELL_W'(CELL_W'(req_q.row) * CELL_W'(GRID_COLS) + CELL_W'(req_q.col));

	always_comb begin
		mem_we   = 1'b0;
		mem_wd   = 1'b0;
		mem_addr = '0;
		if (cmd.clr_step) begin
			mem_we   = 1'b1;
			mem_addr = clr_addr_q;
		end else if (cmd.ev_rd && nb_ok) begin
			mem_addr = nb_addr;
		end else if (cmd.wr_rd) begin
			mem_addr = ctr_addr;
		end else if (cmd.wr_upd) begin
			mem_addr = ctr_addr;
			mem_we   = rd_data_q != req_q.cell_value;
			mem_wd   = req_q.cell_value;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_addr] <= mem_wd;
		end
		rd_data_q <= mem_q[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			nb_q       <= '0;
			nb_vld_s1  <= 1'b0;
			sum_q      <= '0;
			pop_q      <= '0;
		end else begin
			nb_vld_s1 <= cmd.ev_rd && nb_ok;
			if (cmd.clr_step) begin
				clr_addr_q <= stat.clr_last ? '0 : clr_addr_q + 1'b1;
				pop_q      <= '0;
			end
			if (cmd.load) begin
				nb_q  <= '0;
				sum_q <= '0;
			end else begin
				if (cmd.ev_rd) nb_q <= nb_q + 1'b1;
				if (nb_vld_s1 && rd_data_q) sum_q <= sum_q + 1'b1;
			end
			if (cmd.wr_upd && rd_data_q != req_q.cell_value) begin
				if (req_q.cell_value) begin
					pop_q <= pop_q + 1'b1;
				end else if (pop_q != '0) begin
					pop_q <= pop_q - 1'b1;
				end
			end
		end
	end

	assign stat.in_grid  = (32'(req.row) < GRID_ROWS) && (32'(req.col) < GRID_COLS);
	assign stat.clr_last = clr_addr_q == CELL_W'(CELLS - 1);
	assign stat.nb_last  = nb_q == lcge_pkg::NB_W'(lcge_pkg::NB_NUM - 1);

	// B3/S23
	assign alive = (sum_q == lcge_pkg::SUM_W'(lcge_pkg::BORN_CNT))
	            || (!req_q.center_dead && sum_q == lcge_pkg::SUM_W'(lcge_pkg::KEEP_CNT));

	assign rsp.next_state = cmd.rsp && req_q.req_type == lcge_pkg::REQ_EVAL && alive;
	assign rsp.live_count = pop_q;

endmodule

`default_nettype wire

// File: rtl/life_cell_grid_engine_core.sv
// Conway B3/S23 cell engine over a GRID_ROWS x GRID_COLS one-bit grid held in a
// single-port memory. A request is taken when start is high and busy is low; its
// single result appears on rsp for exactly one cycle with done high, and must be
// taken then (the block cannot be stalled). Steps from accept to done, in order:
// evaluate: eight neighbor reads, one per cycle through the one memory port, a
// step to sum the last, a result step; write: read old cell, update, result;
// clear: the memory is zeroed one cell a cycle, then the result; out-of-grid or
// unused requests: straight to the result. After reset the block sweeps the memory
// to zero and holds busy high until the sweep ends, before the first accept.
`default_nettype none

module life_cell_grid_engine_core #(
	parameter int GRID_ROWS = 64,
	parameter int GRID_COLS = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire lcge_pkg::req_t req,
	output logic                busy,
	output logic                done,
	output lcge_pkg::rsp_t      rsp
);

	lcge_pkg::cmd_t  cmd;
	lcge_pkg::stat_t stat;

	lcge_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req.req_type),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done)
	);

	lcge_dpath #(
		.GRID_ROWS (GRID_ROWS),
		.GRID_COLS (GRID_COLS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accept");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result shown while idle");

	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.live_count <= lcge_pkg::MAX_LIVE))
		else $error("live count out of range");

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps

class grid_tracker;
	localparam int ROWS = 64;
	localparam int COLS = 64;

	bit [COLS-1:0]  cells [ROWS];
	int unsigned    live;
	lcge_pkg::rsp_t due_q [$];
	int             errors;

	function new();
		foreach (cells[i])
			cells[i] = '0;
		live   = 0;
		errors = 0;
	endfunction

	function int live_neighbors(int r, int c);
		int n;
		n = 0;
		for (int dr = -1; dr <= 1; dr++)
			for (int dc = -1; dc <= 1; dc++)
				if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < ROWS &&
				    c + dc >= 0 && c + dc < COLS)
					n += cells[r + dr][c + dc];
		return n;
	endfunction

	function void note_request(lcge_pkg::req_t r);
		lcge_pkg::rsp_t e;
		int   n;
		bit   in_grid;
		e.next_state = 1'b0;
		in_grid = (int'(r.row) < ROWS) && (int'(r.col) < COLS);
		case (r.req_type)
			lcge_pkg::REQ_WRITE: begin
				if (in_grid && cells[r.row][r.col] != r.cell_value) begin
					cells[r.row][r.col] = r.cell_value;
					if (r.cell_value)
						live++;
					else if (live > 0)
						live--;
				end
			end
			lcge_pkg::REQ_EVAL: begin
				if (in_grid) begin
					n = live_neighbors(r.row, r.col);
					if (r.center_dead)
						e.next_state = (n == lcge_pkg::BORN_CNT);
					else
						e.next_state = (n == lcge_pkg::KEEP_CNT) ||
						               (n == lcge_pkg::BORN_CNT);
				end
			end
			lcge_pkg::REQ_CLEAR: begin
				foreach (cells[i])
					cells[i] = '0;
				live = 0;
			end
			default: ;
		endcase
		e.live_count = lcge_pkg::POP_W'(live);
		due_q.push_back(e);
	endfunction

	function void check_response(lcge_pkg::rsp_t got);
		lcge_pkg::rsp_t e;
		if (due_q.size() == 0) begin
			$display("%0t: response with none due: next_state=%0d live_count=%0d",
			         $time, got.next_state, got.live_count);
			errors++;
			return;
		end
		e = due_q.pop_front();
		if (got.next_state !== e.next_state) begin
			$display("%0t: next_state mismatch: expected %0d, got %0d",
			         $time, e.next_state, got.next_state);
			errors++;
		end
		if (got.live_count !== e.live_count) begin
			$display("%0t: live_count mismatch: expected %0d, got %0d",
			         $time, e.live_count, got.live_count);
			errors++;
		end
	endfunction
endclass

module testbench;
	localparam int N_RANDOM = 500;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic start;
	lcge_pkg::req_t req;
	logic busy;
	logic done;
	lcge_pkg::rsp_t rsp;

	grid_tracker tracker = new();

	int focus_row;
	int focus_col;

	life_cell_grid_engine_core #(
		.GRID_ROWS(64),
		.GRID_COLS(64)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.req   (req),
		.busy  (busy),
		.done  (done),
		.rsp   (rsp)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			tracker.check_response(rsp);
	end

	function automatic lcge_pkg::req_t make_req(logic [1:0] kind, int r, int c, bit v,
	                                            bit dead);
		lcge_pkg::req_t q;
		q.req_type    = kind;
		q.row         = lcge_pkg::ADDR_W'(r);
		q.col         = lcge_pkg::ADDR_W'(c);
		q.cell_value  = v;
		q.center_dead = dead;
		return q;
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50)
			return 0;
		else if (p < 85)
			return $urandom_range(1, 3);
		else if (p < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// one beat: hold start until taken, then optionally drop it for a gap
	task automatic send(input lcge_pkg::req_t r, input int gap);
		req   <= r;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		tracker.note_request(r);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_directed(input logic [1:0] kind, input int r, input int c,
	                             input bit v, input bit dead);
		send(make_req(kind, r, c, v, dead), pick_gap());
	endtask

	function automatic lcge_pkg::req_t random_req();
		int   p;
		int   r;
		int   c;
		logic [1:0] kind;
		p = $urandom_range(0, 199);
		if (p < 2)
			kind = lcge_pkg::REQ_CLEAR;
		else if (p < 9)
			kind = REQ_UNUSED;
		else if (p < 100)
			kind = lcge_pkg::REQ_WRITE;
		else
			kind = lcge_pkg::REQ_EVAL;
		if ($urandom_range(0, 29) == 0) begin
			focus_row = ($urandom_range(0, 2) == 0) ? 60 * $urandom_range(0, 1)
			                                        : $urandom_range(0, 60);
			focus_col = ($urandom_range(0, 2) == 0) ? 60 * $urandom_range(0, 1)
			                                        : $urandom_range(0, 60);
		end
		if ($urandom_range(0, 9) == 0) begin
			r = $urandom_range(0, 63);
			c = $urandom_range(0, 63);
		end else begin
			r = focus_row + $urandom_range(0, 3);
			c = focus_col + $urandom_range(0, 3);
		end
		return make_req(kind, r, c, $urandom_range(0, 9) < 6, 1'($urandom_range(0, 1)));
	endfunction

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		req       = '0;
		focus_row = 0;
		focus_col = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// births, survival, crowding, corners
		send_directed(lcge_pkg::REQ_WRITE, 0, 0, 1'b1, 1'b0);
		send_directed(lcge_pkg::REQ_WRITE, 0, 1, 1'b1, 1'b1);
		send_directed(lcge_pkg::REQ_WRITE, 1, 0, 1'b1, 1'b0);
		send_directed(lcge_pkg::REQ_EVAL, 1, 1, 1'b0, 1'b1);
		send_directed(lcge_pkg::REQ_EVAL, 0, 0, 1'b1, 1'b0);
		send_directed(lcge_pkg::REQ_WRITE, 1, 1, 1'b1, 1'b0);
		send_directed(lcge_pkg::REQ_WRITE, 0, 2, 1'b1, 1'b0);
		send_directed(lcge_pkg::REQ_EVAL, 1, 1, 1'b0, 1'b0);
		send_directed(lcge_pkg::REQ_EVAL, 2, 0, 1'b0, 1'b1);
		send_directed(lcge_pkg::REQ_WRITE, 0, 0, 1'b1, 1'b0);
		send_directed(lcge_pkg::REQ_WRITE, 5, 5, 1'b0, 1'b1);
		send_directed(lcge_pkg::REQ_WRITE, 63, 63, 1'b1, 1'b0);
		send_directed(lcge_pkg::REQ_WRITE, 63, 62, 1'b1, 1'b0);
		send_directed(lcge_pkg::REQ_WRITE, 62, 63, 1'b1, 1'b0);
		send_directed(lcge_pkg::REQ_EVAL, 62, 62, 1'b0, 1'b1);
		send_directed(lcge_pkg::REQ_EVAL, 63, 63, 1'b1, 1'b0);
		send_directed(lcge_pkg::REQ_EVAL, 63, 0, 1'b0, 1'b0);
		send_directed(lcge_pkg::REQ_EVAL, 0, 63, 1'b1, 1'b1);
		send_directed(REQ_UNUSED, 63, 63, 1'b1, 1'b1);
		send_directed(lcge_pkg::REQ_WRITE, 63, 63, 1'b0, 1'b1);
		send_directed(lcge_pkg::REQ_CLEAR, 63, 0, 1'b1, 1'b1);
		send_directed(lcge_pkg::REQ_EVAL, 0, 0, 1'b0, 1'b0);
		send_directed(lcge_pkg::REQ_WRITE, 0, 63, 1'b1, 1'b0);

		for (int i = 0; i < N_RANDOM; i++)
			send(random_req(), pick_gap());
		start <= 1'b0;

		while (tracker.due_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (tracker.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout at %0t", $time);
		$display("*** FAILED ***");
		$finish;
	end
endmodule
